[design/bm3_pkg.sv]
`default_nettype none
//----------------------------------------------------------------------------
// bm3_pkg: shared types and constants of the 3x3 binary morphology block
// Register codes, window operations, control structs and field widths.
//----------------------------------------------------------------------------
package bm3_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_CHANNELS  = 3;

    localparam int CHAN_W       = 8;
    localparam int OUT_CHANNELS = 3;
    localparam int OUT_PIX_W    = CHAN_W * OUT_CHANNELS;
    localparam int WIN_CELLS    = 9;
    localparam int MASK_W       = WIN_CELLS;
    localparam int FW_W         = 11;
    localparam int FH_W         = 13;
    localparam int DIM_W        = 13;
    localparam int MAX_HEIGHT   = 4096;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam int RST_WIDTH  = 1024;
    localparam int RST_HEIGHT = 1024;
    localparam logic [MASK_W-1:0] RST_MASK   = 9'h1FF;
    localparam logic [CHAN_W-1:0] FULL_VALUE = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_MASK   = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_DILATION = 2'd0,
        MODE_EROSION  = 2'd1,
        MODE_OPENING  = 2'd2,
        MODE_CLOSING  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_PASS   = 2'd0,
        OP_DILATE = 2'd1,
        OP_ERODE  = 2'd2
    } t_op;

    // Request entering one window stage.
    typedef struct packed {
        logic push;
        logic clr;
        logic interior;
    } t_win_ctl;

    // Second-stage control, carried in a register behind the stage-one request.
    typedef struct packed {
        logic push;
        logic zero;
        logic clr;
        logic interior;
    } t_s2_ctl;

    typedef struct packed {
        logic produce;
        logic last;
    } t_out_ctl;

    typedef struct packed {
        logic              last;
        logic [CHAN_W-1:0] chan2;
        logic [CHAN_W-1:0] chan1;
        logic [CHAN_W-1:0] chan0;
    } t_out_item;

endpackage
`default_nettype wire

[design/bm3_ram.sv]
`default_nettype none
//----------------------------------------------------------------------------
// bm3_ram: generic single-clock RAM
// One write port and one read port, read data registered.
//----------------------------------------------------------------------------
module bm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[design/bm3_stage.sv]
`default_nettype none
//----------------------------------------------------------------------------
// bm3_stage: one 3x3 window stage
// Two-row line buffer in RAM, window shift and the dilate/erode decision.
//----------------------------------------------------------------------------
module bm3_stage
    import bm3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int PIX_W     = CHAN_W * DEF_CHANNELS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_adv,
    input  wire t_op                          i_op,
    input  wire logic [MASK_W-1:0]            i_mask,
    input  wire t_win_ctl                     i_req,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_req_addr,
    input  wire logic [PIX_W-1:0]             i_req_value,
    output logic      [PIX_W-1:0]             o_res
);

    localparam int CW = $clog2(MAX_WIDTH);

    t_win_ctl           r_cur;
    logic [CW-1:0]      r_addr;
    logic [PIX_W-1:0]   r_value;
    logic               r_fwd;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic [PIX_W-1:0]   r_win [WIN_CELLS];

    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] lines;
    logic [2*PIX_W-1:0] wdata;
    logic [PIX_W-1:0]   n_win [WIN_CELLS];
    logic               hit_full;
    logic               hit_zero;

    bm3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (i_adv & r_cur.push),
        .i_waddr (r_addr),
        .i_wdata (wdata),
        .i_re    (i_adv & i_req.push),
        .i_raddr (i_req_addr),
        .o_rdata (ram_rdata)
    );

    // The upper half holds the row two lines back, the lower half one line back.
    assign lines = r_fwd ? r_fwd_data : ram_rdata;
    assign wdata = {lines[PIX_W-1:0], r_value};

    always_comb begin
        for (int k = 0; k < WIN_CELLS - 3; k++) begin
            n_win[k] = r_cur.clr ? '0 : r_win[k + 3];
        end
        n_win[6] = lines[2*PIX_W-1:PIX_W];
        n_win[7] = lines[PIX_W-1:0];
        n_win[8] = r_value;
    end

    always_comb begin
        hit_full = 1'b0;
        hit_zero = 1'b0;
        for (int k = 0; k < WIN_CELLS; k++) begin
            if (i_mask[k] && (n_win[k][CHAN_W-1:0] == FULL_VALUE)) begin
                hit_full = 1'b1;
            end
            if (i_mask[k] && (n_win[k][CHAN_W-1:0] == '0)) begin
                hit_zero = 1'b1;
            end
        end
    end

    always_comb begin
        o_res = n_win[4];
        case (i_op)
            OP_DILATE: begin
                if (r_cur.interior && hit_full) begin
                    o_res = '1;
                end
            end
            OP_ERODE: begin
                if (r_cur.interior && hit_zero) begin
                    o_res = '0;
                end
            end
            default: begin
                o_res = n_win[4];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_fwd <= 1'b0;
        end else if (i_adv) begin
            r_cur <= i_req;
            // The entry read now is being written at this same edge.
            r_fwd <= i_req.push && r_cur.push && (i_req_addr == r_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_addr     <= i_req_addr;
            r_value    <= i_req_value;
            r_fwd_data <= wdata;
            if (r_cur.push) begin
                r_win <= n_win;
            end
        end
    end

`ifndef ASSERT_OFF
    a_fwd_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_cur.push)
        else $error("forwarded line data without a pending request");
`endif

endmodule
`default_nettype wire

[design/bm3_outq.sv]
`default_nettype none
//----------------------------------------------------------------------------
// bm3_outq: two-entry output queue
// Holds finished results so the pipeline keeps moving while the sink stalls.
//----------------------------------------------------------------------------
module bm3_outq
    import bm3_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output t_out_item      o_item,
    input  wire logic      i_stall
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_out_item  r_slot0;
    t_out_item  r_slot1;
    t_out_item  n_slot0;
    t_out_item  n_slot1;
    logic       pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot0;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        case ({i_push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_slot0 = i_item;
                end else begin
                    n_slot1 = i_item;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_slot0 = r_slot1;
                n_cnt   = r_cnt - 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_slot0 = i_item;
                end else begin
                    n_slot0 = r_slot1;
                    n_slot1 = i_item;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("result pushed into a full output queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");
`endif

endmodule
`default_nettype wire

[design/binary_morphology_3x3.sv]
`default_nettype none
//----------------------------------------------------------------------------
// binary_morphology_3x3: 3x3 binary dilation, erosion, opening and closing
// Raster-order pixel stream in, filtered pixel stream out.
//----------------------------------------------------------------------------
// Usage. Pixels enter on the input channel (i_valid / o_stall) one request
// per pixel, row by row; i_action set marks a flush request that carries no
// pixel. Results leave on the output channel (o_valid / i_stall), at most one
// per input request. A pixel's result is released by the request that comes
// 2*(width+1) positions after it, so a frame is drained by 2*(width+1) flush
// requests; the final pixel carries o_last_of_frame and restarts the frame.
// A result passes the stage-one and stage-two line-buffer reads and the
// output queue after the releasing request is accepted. Throughput is one
// request per cycle while the output queue is not full, set by each stage's
// line-buffer RAM, which takes one read and one write every cycle.
// Reset clears the position counters and both windows and loads the
// register defaults; the line buffers are not cleared, since entries not yet
// written only ever feed border pixels, which pass through unchanged.
// When the receiver stalls, results collect in a two-entry output queue;
// o_stall rises once that queue is full. Any configuration write restarts
// the frame and must be done while the block is idle.
//----------------------------------------------------------------------------
module binary_morphology_3x3
    import bm3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int CHANNELS  = DEF_CHANNELS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_action,
    input  wire logic [CHAN_W-1:0]     i_chan0,
    input  wire logic [CHAN_W-1:0]     i_chan1,
    input  wire logic [CHAN_W-1:0]     i_chan2,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [CHAN_W-1:0]     o_out_chan0,
    output logic      [CHAN_W-1:0]     o_out_chan1,
    output logic      [CHAN_W-1:0]     o_out_chan2,
    output logic                       o_last_of_frame,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Only the channels that are carried take storage.
    localparam int USED    = (CHANNELS < OUT_CHANNELS) ? CHANNELS : OUT_CHANNELS;
    localparam int PIX_W   = CHAN_W * USED;
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RST_WM1 = ((MAX_WIDTH < RST_WIDTH) ? MAX_WIDTH : RST_WIDTH) - 1;

    // Configuration registers, kept in their effective (saturated) form.
    t_mode             r_mode;
    logic [MASK_W-1:0] r_mask;
    logic [CW-1:0]     r_wm1;
    logic [DIM_W-1:0]  r_h;
    logic [DIM_W-1:0]  r_hm1;

    logic [DIM_W-1:0]  cfg_w_ext;
    logic [DIM_W-1:0]  cfg_w_eff;
    logic [DIM_W-1:0]  cfg_h_ext;
    logic [DIM_W-1:0]  cfg_h_eff;

    // Three raster positions: stage one input, stage two input, output.
    logic [CW-1:0]     r_p1c, n_p1c, r_p2c, n_p2c, r_p3c, n_p3c;
    logic [DIM_W-1:0]  r_p1r, n_p1r, r_p2r, n_p2r, r_p3r, n_p3r;
    logic              r_clr1, n_clr1, r_clr2, n_clr2;

    logic              adv;
    logic              accept;
    logic              q_full;
    logic              in1, in2, q_ge0, s_ge0, produce, last;
    logic              interior1, interior2;
    t_op               op1, op2;

    t_win_ctl          s1_req, s2_req;
    logic [PIX_W-1:0]  s1_value, s2_value;
    logic [PIX_W-1:0]  res1, res2;
    logic [OUT_PIX_W-1:0] res2_ext;

    t_s2_ctl           r_a_ctl;
    logic [CW-1:0]     r_a_addr;
    t_out_ctl          r_a_out, r_b_out;
    t_out_item         q_in, q_out;

    // ------------------------------------------------------------------
    // Configuration. Width saturates into 1..MAX_WIDTH and height into
    // 1..MAX_HEIGHT before it is stored.
    // ------------------------------------------------------------------
    assign cfg_w_ext = DIM_W'(i_cfg_data[FW_W-1:0]);
    assign cfg_h_ext = DIM_W'(i_cfg_data[FH_W-1:0]);

    always_comb begin
        if (cfg_w_ext == '0) begin
            cfg_w_eff = DIM_W'(1);
        end else if (cfg_w_ext > DIM_W'(MAX_WIDTH)) begin
            cfg_w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            cfg_w_eff = cfg_w_ext;
        end
        if (cfg_h_ext == '0) begin
            cfg_h_eff = DIM_W'(1);
        end else if (cfg_h_ext > DIM_W'(MAX_HEIGHT)) begin
            cfg_h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            cfg_h_eff = cfg_h_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DILATION;
            r_mask <= RST_MASK;
            r_wm1  <= CW'(RST_WM1);
            r_h    <= DIM_W'(RST_HEIGHT);
            r_hm1  <= DIM_W'(RST_HEIGHT - 1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE: begin
                    r_mode <= t_mode'(i_cfg_data[1:0]);
                end
                CFG_MASK: begin
                    r_mask <= i_cfg_data[MASK_W-1:0];
                end
                CFG_WIDTH: begin
                    r_wm1 <= CW'(cfg_w_eff - DIM_W'(1));
                end
                CFG_HEIGHT: begin
                    r_h   <= cfg_h_eff;
                    r_hm1 <= cfg_h_eff - DIM_W'(1);
                end
            endcase
        end
    end

    // Opening is erosion then dilation, closing the reverse; single
    // operations leave the second stage passing pixels through.
    always_comb begin
        unique case (r_mode)
            MODE_DILATION: begin
                op1 = OP_DILATE;
                op2 = OP_PASS;
            end
            MODE_EROSION: begin
                op1 = OP_ERODE;
                op2 = OP_PASS;
            end
            MODE_OPENING: begin
                op1 = OP_ERODE;
                op2 = OP_DILATE;
            end
            MODE_CLOSING: begin
                op1 = OP_DILATE;
                op2 = OP_ERODE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Request control. Everything about a request is decided from the
    // position counters at the moment it is accepted.
    // ------------------------------------------------------------------
    assign adv     = ~q_full;
    assign o_stall = q_full | ~i_rst_n;
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        // Stage one still inside the frame: the request carries a pixel.
        in1   = (r_p1r < r_h);
        // Stage two is fed once stage one is a row and a pixel deep.
        q_ge0 = (r_p1r >= DIM_W'(2)) || ((r_p1r == DIM_W'(1)) && (r_p1c != '0));
        in2   = (r_p2r < r_h);
        s_ge0 = q_ge0 &&
                ((r_p2r >= DIM_W'(2)) || ((r_p2r == DIM_W'(1)) && (r_p2c != '0)));
        produce = s_ge0 && (r_p3r < r_h);
        last    = produce && (r_p3r == r_hm1) && (r_p3c == r_wm1);
        // The window centre sits one row and one column behind the entry
        // point; it is inside the frame border exactly in this range.
        interior1 = (r_p1c >= CW'(2)) && (r_p1r >= DIM_W'(2)) && (r_p1r < r_h);
        interior2 = (r_p2c >= CW'(2)) && (r_p2r >= DIM_W'(2)) && (r_p2r < r_h);
    end

    always_comb begin
        n_p1c  = r_p1c;
        n_p1r  = r_p1r;
        n_p2c  = r_p2c;
        n_p2r  = r_p2r;
        n_p3c  = r_p3c;
        n_p3r  = r_p3r;
        n_clr1 = r_clr1;
        n_clr2 = r_clr2;
        if (i_cfg_we || (accept && last)) begin
            // Frame restart: counters back to zero, windows cleared by the
            // next request entering each stage.
            n_p1c  = '0;
            n_p1r  = '0;
            n_p2c  = '0;
            n_p2r  = '0;
            n_p3c  = '0;
            n_p3r  = '0;
            n_clr1 = 1'b1;
            n_clr2 = 1'b1;
        end else if (accept) begin
            n_clr1 = 1'b0;
            if (r_p1c == r_wm1) begin
                n_p1c = '0;
                n_p1r = r_p1r + DIM_W'(1);
            end else begin
                n_p1c = r_p1c + CW'(1);
            end
            if (q_ge0) begin
                n_clr2 = 1'b0;
                if (r_p2c == r_wm1) begin
                    n_p2c = '0;
                    n_p2r = r_p2r + DIM_W'(1);
                end else begin
                    n_p2c = r_p2c + CW'(1);
                end
            end
            if (s_ge0) begin
                if (r_p3c == r_wm1) begin
                    n_p3c = '0;
                    n_p3r = r_p3r + DIM_W'(1);
                end else begin
                    n_p3c = r_p3c + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1c  <= '0;
            r_p1r  <= '0;
            r_p2c  <= '0;
            r_p2r  <= '0;
            r_p3c  <= '0;
            r_p3r  <= '0;
            r_clr1 <= 1'b1;
            r_clr2 <= 1'b1;
        end else begin
            r_p1c  <= n_p1c;
            r_p1r  <= n_p1r;
            r_p2c  <= n_p2c;
            r_p2r  <= n_p2r;
            r_p3c  <= n_p3c;
            r_p3r  <= n_p3r;
            r_clr1 <= n_clr1;
            r_clr2 <= n_clr2;
        end
    end

    // ------------------------------------------------------------------
    // Stage one takes every request; past the frame and on a flush it is fed zeros.
    // ------------------------------------------------------------------
    assign s1_req   = '{push: accept, clr: r_clr1, interior: interior1};
    assign s1_value = (in1 && !i_action) ? PIX_W'({i_chan2, i_chan1, i_chan0}) : '0;

    bm3_stage #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIX_W     (PIX_W)
    ) u_stage1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_op        (op1),
        .i_mask      (r_mask),
        .i_req       (s1_req),
        .i_req_addr  (r_p1c),
        .i_req_value (s1_value),
        .o_res       (res1)
    );

    // Second-stage and output control follow the request down the pipe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_a_out <= '0;
            r_b_out <= '0;
        end else if (adv) begin
            r_a_ctl <= '{push: accept && q_ge0, zero: !in2, clr: r_clr2,
                         interior: interior2};
            r_a_out <= '{produce: accept && produce, last: last};
            r_b_out <= r_a_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_addr <= r_p2c;
        end
    end

    // ------------------------------------------------------------------
    // Stage two takes the stage-one result, its request carried in r_a_ctl.
    // ------------------------------------------------------------------
    assign s2_req   = '{push: r_a_ctl.push, clr: r_a_ctl.clr, interior: r_a_ctl.interior};
    assign s2_value = r_a_ctl.zero ? '0 : res1;

    bm3_stage #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIX_W     (PIX_W)
    ) u_stage2 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_op        (op2),
        .i_mask      (r_mask),
        .i_req       (s2_req),
        .i_req_addr  (r_a_addr),
        .i_req_value (s2_value),
        .o_res       (res2)
    );

    // Channels that are not carried come out as zero.
    assign res2_ext = OUT_PIX_W'(res2);
    assign q_in = '{last:  r_b_out.last,
                    chan2: res2_ext[3*CHAN_W-1:2*CHAN_W],
                    chan1: res2_ext[2*CHAN_W-1:CHAN_W],
                    chan0: res2_ext[CHAN_W-1:0]};

    bm3_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv & r_b_out.produce),
        .i_item  (q_in),
        .o_full  (q_full),
        .o_valid (o_valid),
        .o_item  (q_out),
        .i_stall (i_stall)
    );

    assign o_out_chan0     = q_out.chan0;
    assign o_out_chan1     = q_out.chan1;
    assign o_out_chan2     = q_out.chan2;
    assign o_last_of_frame = q_out.last;

`ifndef ASSERT_OFF
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> ((r_p1c == '0) && (r_p1r == '0) && r_clr1 && r_clr2))
        else $error("frame did not restart after its last pixel");
    a_produce_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_out.produce |-> r_a_ctl.push)
        else $error("result scheduled without a second-stage request");
`endif

endmodule
`default_nettype wire

[sim/tb_binary_morphology_3x3.sv]
`timescale 1ns / 100ps
//----------------------------------------------------------------------------
// tb_binary_morphology_3x3: self-checking bench for the 3x3 morphology block
// A cycle-free model of both window stages predicts every output pixel from
// the accepted requests; results are compared field by field, in order.
//----------------------------------------------------------------------------
import bm3_pkg::*;

// Tracks the block's frame position, line buffers and windows per accepted
// request and keeps the output pixels that are due, oldest first.
class morph_tracker;
    t_mode                  mode_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic [FW_W-1:0]        width_reg;
    logic [FH_W-1:0]        height_reg;
    logic [OUT_PIX_W-1:0]   line_rows [2][2*DEF_MAX_WIDTH];
    logic [OUT_PIX_W-1:0]   window [2][WIN_CELLS];
    int                     col [2];
    int                     row [2];
    int                     taken;
    t_out_item              due_pixels [$];
    int                     errors;

    function new();
        mode_reg   = MODE_DILATION;
        mask_reg   = RST_MASK;
        width_reg  = FW_W'(RST_WIDTH);
        height_reg = FH_W'(RST_HEIGHT);
        errors     = 0;
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < 2*DEF_MAX_WIDTH; i++) begin
                line_rows[s][i] = '0;
            end
        end
        restart_frame();
    endfunction

    function void restart_frame();
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < WIN_CELLS; k++) begin
                window[s][k] = '0;
            end
            col[s] = 0;
            row[s] = 0;
        end
        taken = 0;
    endfunction

    function int eff_width();
        int w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        return w;
    endfunction

    function int eff_height();
        int h;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function int pending();
        return due_pixels.size();
    endfunction

    // Every register write restarts the frame; the line buffers survive.
    function void set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MODE:   mode_reg   = t_mode'(data[1:0]);
            CFG_MASK:   mask_reg   = data[MASK_W-1:0];
            CFG_WIDTH:  width_reg  = data[FW_W-1:0];
            CFG_HEIGHT: height_reg = data[FH_W-1:0];
        endcase
        restart_frame();
    endfunction

    // Shifts one pixel into a stage and returns the filtered window centre,
    // which lags the entering pixel by one row and one column.
    function logic [OUT_PIX_W-1:0] slide_window(int st, logic [OUT_PIX_W-1:0] value,
                                                t_op op, int w, int h);
        int pc, pr, idx, cc, cr;
        logic [OUT_PIX_W-1:0] centre;
        bit hit;
        pc  = col[st];
        pr  = row[st];
        idx = (pc < DEF_MAX_WIDTH) ? pc : DEF_MAX_WIDTH - 1;
        for (int k = 0; k < 6; k++) begin
            window[st][k] = window[st][k+3];
        end
        window[st][6] = line_rows[st][DEF_MAX_WIDTH + idx];
        window[st][7] = line_rows[st][idx];
        window[st][8] = value;
        line_rows[st][DEF_MAX_WIDTH + idx] = line_rows[st][idx];
        line_rows[st][idx] = value;
        if (pc == 0) begin
            cc = w - 1;
            cr = pr - 2;
        end else begin
            cc = pc - 1;
            cr = pr - 1;
        end
        pc++;
        if (pc >= w) begin
            pc = 0;
            pr++;
        end
        col[st] = pc;
        row[st] = pr;
        centre  = window[st][4];
        if (op == OP_PASS || cr < 1 || cr > h - 2 || cc < 1 || cc > w - 2) return centre;
        hit = 1'b0;
        for (int k = 0; k < WIN_CELLS; k++) begin
            if (mask_reg[k]) begin
                if (op == OP_DILATE && window[st][k][CHAN_W-1:0] == FULL_VALUE) hit = 1'b1;
                if (op == OP_ERODE && window[st][k][CHAN_W-1:0] == '0) hit = 1'b1;
            end
        end
        if (!hit) return centre;
        return (op == OP_DILATE) ? {OUT_CHANNELS{FULL_VALUE}} : '0;
    endfunction

    function void take_request(logic act, logic [CHAN_W-1:0] c0, logic [CHAN_W-1:0] c1,
                               logic [CHAN_W-1:0] c2);
        int w, h, n, k, q, s;
        t_op first_op, second_op;
        logic [OUT_PIX_W-1:0] v, r1, r2;
        t_out_item item;
        w = eff_width();
        h = eff_height();
        n = w * h;
        k = taken;
        q = k - (w + 1);
        case (mode_reg)
            MODE_DILATION: begin first_op = OP_DILATE; second_op = OP_PASS;   end
            MODE_EROSION:  begin first_op = OP_ERODE;  second_op = OP_PASS;   end
            MODE_OPENING:  begin first_op = OP_ERODE;  second_op = OP_DILATE; end
            default:       begin first_op = OP_DILATE; second_op = OP_ERODE;  end
        endcase
        // A flush inside the frame, and anything past its last pixel, is black.
        v = (k < n && !act) ? {c2, c1, c0} : '0;
        r1 = slide_window(0, v, first_op, w, h);
        taken = k + 1;
        if (q >= 0) begin
            r2 = slide_window(1, (q < n) ? r1 : '0, second_op, w, h);
            s  = q - (w + 1);
            if (s >= 0 && s < n) begin
                item.chan0 = r2[CHAN_W-1:0];
                item.chan1 = r2[2*CHAN_W-1:CHAN_W];
                item.chan2 = r2[3*CHAN_W-1:2*CHAN_W];
                item.last  = (s == n - 1);
                due_pixels.push_back(item);
                if (item.last) restart_frame();
            end
        end
    endfunction

    function void report(string field, int want, int got);
        errors++;
        if (errors <= 100) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    function void check_pixel(t_out_item got);
        t_out_item want;
        if (due_pixels.size() == 0) begin
            errors++;
            if (errors <= 100) begin
                $display("%0t: pixel with nothing expected, actual %0d/%0d/%0d last %0d",
                         $time, got.chan0, got.chan1, got.chan2, got.last);
            end
            return;
        end
        want = due_pixels.pop_front();
        if (got.chan0 !== want.chan0) report("chan0", want.chan0, got.chan0);
        if (got.chan1 !== want.chan1) report("chan1", want.chan1, got.chan1);
        if (got.chan2 !== want.chan2) report("chan2", want.chan2, got.chan2);
        if (got.last !== want.last)   report("last_of_frame", want.last, got.last);
    endfunction
endclass

module tb_binary_morphology_3x3;

    localparam int LIMIT_NS = 60_000_000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_action;
    logic [CHAN_W-1:0]      i_chan0;
    logic [CHAN_W-1:0]      i_chan1;
    logic [CHAN_W-1:0]      i_chan2;
    logic                   o_valid;
    logic                   i_stall;
    logic [CHAN_W-1:0]      o_out_chan0;
    logic [CHAN_W-1:0]      o_out_chan1;
    logic [CHAN_W-1:0]      o_out_chan2;
    logic                   o_last_of_frame;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    morph_tracker tracker = new();
    bit sender_steady = 1'b0;
    bit hold_request  = 1'b0;
    bit hold_active   = 1'b0;

    binary_morphology_3x3 DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Mostly back-to-back requests, some short gaps and the odd long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Channel 0 decides, so it is mostly pure white or pure black.
    function automatic logic [CHAN_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return FULL_VALUE;
        if (r < 75) return '0;
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    task automatic send_request(input logic act, input logic [CHAN_W-1:0] c0,
                                input logic [CHAN_W-1:0] c1, input logic [CHAN_W-1:0] c2);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_chan0  <= c0;
        i_chan1  <= c1;
        i_chan2  <= c2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_request(act, c0, c1, c2);
    endtask

    // One frame in raster order followed by its drain; stop may cut it short.
    task automatic send_frame(int n_pix, int stop);
        for (int i = 0; i < stop; i++) begin
            if (i < n_pix) begin
                send_request($urandom_range(0, 19) == 0, pick_level(),
                             CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
            end else begin
                send_request($urandom_range(0, 4) != 0, pick_level(),
                             CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // Waits for every due pixel, then for the pipeline to empty behind it.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(t_mode mode_val, logic [MASK_W-1:0] mask_val,
                                logic [FW_W-1:0] w_val, logic [FH_W-1:0] h_val);
        t_cfg_idx idx;
        logic [CFG_DATA_W-1:0] data;
        i_cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            idx = t_cfg_idx'(i);
            case (idx)
                CFG_MODE:   data = CFG_DATA_W'(mode_val);
                CFG_MASK:   data = CFG_DATA_W'(mask_val);
                CFG_WIDTH:  data = CFG_DATA_W'(w_val);
                default:    data = CFG_DATA_W'(h_val);
            endcase
            i_cfg_idx  <= idx;
            i_cfg_data <= data;
            @(posedge i_clk);
            tracker.set_register(idx, data);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Output side: random stalls, calm stretches, and on request one long
    // hold-off so that the block backs up into its input.
    initial begin
        int r, span;
        logic level;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                level = 1'b1;
                span  = 400;
            end else begin
                hold_active = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    level = 1'b0;
                    span  = $urandom_range(30, 150);
                end else if (r < 70) begin
                    level = 1'b0;
                    span  = $urandom_range(1, 4);
                end else if (r < 95) begin
                    level = 1'b1;
                    span  = $urandom_range(1, 3);
                end else begin
                    level = 1'b1;
                    span  = $urandom_range(15, 60);
                end
            end
            i_stall <= level;
            repeat (span) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_pixel(t_out_item'({o_last_of_frame, o_out_chan2,
                                             o_out_chan1, o_out_chan0}));
        end
    end

    initial begin
        int phase, sent_items, n_pix, total, frames, stop, r;
        bit big_phase;
        t_mode mode_val;
        logic [MASK_W-1:0] mask_val;
        logic [FW_W-1:0] w_val;
        logic [FH_W-1:0] h_val;

        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_action   <= 1'b0;
        i_chan0    <= '0;
        i_chan1    <= '0;
        i_chan2    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_MODE;
        i_cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A few requests under the reset configuration; a 1024x1024 frame
        // is far too long to finish, so none of them completes a pixel.
        for (int i = 0; i < 5; i++) begin
            send_request(1'b0, pick_level(), CHAN_W'($urandom_range(0, 255)),
                         CHAN_W'($urandom_range(0, 255)));
        end
        wait_idle();

        // Directed 3x3 opening: channel extremes, near misses of the exact
        // tests, a flush inside the frame and pixels past the frame end.
        write_config(MODE_OPENING, RST_MASK, 11'd3, 13'd3);
        send_request(1'b0, 8'hFF, 8'h00, 8'hFF);
        send_request(1'b0, 8'hFF, 8'hFF, 8'h00);
        send_request(1'b0, 8'h00, 8'h80, 8'h7F);
        send_request(1'b0, 8'hFE, 8'h01, 8'hFE);
        send_request(1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_request(1'b0, 8'h01, 8'h55, 8'hAA);
        send_request(1'b0, 8'hFF, 8'h00, 8'h00);
        send_request(1'b0, 8'h00, 8'hFF, 8'hFF);
        send_request(1'b0, 8'hFF, 8'h12, 8'h34);
        for (int i = 0; i < 8; i++) begin
            send_request(i % 3 != 0, 8'hFF, 8'hFF, 8'hFF);
        end
        wait_idle();

        // Random phases. A few carry the largest size in one dimension (out-of-range
        // values saturate); only the head of such a frame is sent. The rest are
        // small frames, some cut off by the next configuration write.
        phase = 0;
        sent_items = 0;
        while (phase < 8 || sent_items < 1300) begin
            big_phase = 1'b0;
            case (phase)
                1: begin w_val = 11'h7FF; h_val = 13'd3;     big_phase = 1'b1; end
                4: begin w_val = '0;      h_val = 13'h1FFF;  big_phase = 1'b1; end
                6: begin w_val = 11'd1024; h_val = '0;       big_phase = 1'b1; end
                2, 9: begin
                    w_val = FW_W'($urandom_range(6, 16));
                    h_val = FH_W'($urandom_range(4, 7));
                end
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 10) w_val = FW_W'($urandom_range(1, 2));
                    else if (r < 80) w_val = FW_W'($urandom_range(3, 10));
                    else w_val = FW_W'($urandom_range(11, 40));
                    h_val = FH_W'($urandom_range(1, 7));
                end
            endcase
            mode_val = (phase < 4) ? t_mode'(phase) : t_mode'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 10) mask_val = '0;
            else if (r < 20) mask_val = RST_MASK;
            else mask_val = MASK_W'($urandom_range(0, 511));
            write_config(mode_val, mask_val, w_val, h_val);

            sender_steady = ($urandom_range(0, 3) == 0);
            if (phase == 2 || phase == 9) begin
                hold_request = 1'b1;
                wait (hold_active);
            end

            n_pix  = tracker.eff_width() * tracker.eff_height();
            total  = n_pix + 2 * (tracker.eff_width() + 1);
            frames = big_phase ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                stop = total;
                if (big_phase) begin
                    stop = (total < 200) ? total : 200;
                end else if (f == frames - 1 && $urandom_range(0, 3) == 0) begin
                    stop = $urandom_range(1, total - 1);
                end
                send_frame(n_pix, stop);
                sent_items += stop;
            end
            wait_idle();
            phase++;
        end

        if (tracker.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[binary_morphology_3x3.f]
design/bm3_pkg.sv
design/bm3_ram.sv
design/bm3_stage.sv
design/bm3_outq.sv
design/binary_morphology_3x3.sv
sim/tb_binary_morphology_3x3.sv
